/* rtl/i2crb_pkg.sv */
// ----------------------------------------------------------------------------
// i2crb_pkg
// Shared types and constants for the I2C register burst master.
// ----------------------------------------------------------------------------
package i2crb_pkg;

    localparam int MAX_BURST_DEF = 8;
    localparam logic [6:0] SLAVE_ADDR_RST = 7'd81;

    // depth of the request and result queues
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_PUSH  = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

    typedef struct packed {
        req_t       req;
        logic [7:0] reg_addr;
        logic [3:0] byte_count;
        logic [7:0] data_byte;
        logic       sda_in;
    } cmd_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_release;
        logic       busy_res;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       done_res;
        logic       ack_error;
    } res_t;

endpackage

/* rtl/i2crb_front.sv */
// ----------------------------------------------------------------------------
// i2crb_front
// Accepts request transactions, decodes and clamps them, and queues them for
// the bus engine.
// ----------------------------------------------------------------------------
module i2crb_front #(
    parameter int MAX_BURST = i2crb_pkg::MAX_BURST_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        req_type,
    input  logic [7:0]        reg_addr,
    input  logic [3:0]        byte_count,
    input  logic [7:0]        data_byte,
    input  logic              sda_in,
    output logic              cmd_valid,
    output i2crb_pkg::cmd_t   cmd,
    input  logic              cmd_pop
);
    import i2crb_pkg::*;

    // largest count the four-bit field can carry after clamping
    localparam logic [3:0] CNT_MAX = 4'((MAX_BURST > 15) ? 15 : MAX_BURST);

    cmd_t              dec_cmd;
    cmd_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        dec_cmd.req        = req_t'(req_type);
        dec_cmd.reg_addr   = reg_addr;
        dec_cmd.data_byte  = data_byte;
        dec_cmd.sda_in     = sda_in;
        if (byte_count == 4'd0)
        begin
            dec_cmd.byte_count = 4'd1;
        end
        else if (byte_count > CNT_MAX)
        begin
            dec_cmd.byte_count = CNT_MAX;
        end
        else
        begin
            dec_cmd.byte_count = byte_count;
        end
    end

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign cmd_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;
    assign cmd       = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= dec_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/i2crb_engine.sv */
// ----------------------------------------------------------------------------
// i2crb_engine
// Bus phase sequencer: one line phase per step, write-data buffer, and the
// SCL / SDA line registers.
// ----------------------------------------------------------------------------
module i2crb_engine #(
    parameter int MAX_BURST = i2crb_pkg::MAX_BURST_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             slave_address_we,
    input  logic [6:0]       slave_address,
    input  logic             step,
    input  i2crb_pkg::cmd_t  cmd,
    output i2crb_pkg::res_t  res
);
    import i2crb_pkg::*;

    localparam int PTR_W  = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;
    localparam int FILL_W = $clog2(MAX_BURST + 1);
    localparam logic [3:0] BIT_LAST = 4'd7;

    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_TX_AW, PH_ACK_AW, PH_TX_RA, PH_ACK_RA, PH_TX_D,
        PH_ACK_D, PH_RSTART, PH_TX_AR, PH_ACK_AR, PH_RX, PH_MACK, PH_STOP
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [1:0]        sub_reg, sub_next;
    logic [3:0]        bit_reg, bit_next;
    logic [7:0]        shift_reg, shift_next;
    logic [3:0]        left_reg, left_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic              rmode_reg, rmode_next;
    logic [7:0]        raddr_reg, raddr_next;
    logic              err_reg, err_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic [6:0]        saddr_reg;

    logic [7:0]        tx_buf [MAX_BURST];
    logic [7:0]        rd_data_reg;
    logic [PTR_W-1:0]  rd_addr;
    logic              buf_we;
    logic [3:0]        left_dec;

    logic              rx_valid;
    logic [7:0]        rx_byte;
    logic              done;
    logic              err_out;

    // the next data byte is fetched ahead: during a data acknowledge the
    // address already points past the byte in flight
    assign rd_addr  = (phase_reg == PH_ACK_D) ? ptr_reg + 1'b1 : ptr_reg;
    assign left_dec = (left_reg != 4'd0) ? left_reg - 4'd1 : 4'd0;

    always_comb
    begin
        phase_next = phase_reg;
        sub_next   = sub_reg + 2'd1;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        left_next  = left_reg;
        fill_next  = fill_reg;
        ptr_next   = ptr_reg;
        rmode_next = rmode_reg;
        raddr_next = raddr_reg;
        err_next   = err_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        buf_we     = 1'b0;
        rx_valid   = 1'b0;
        rx_byte    = 8'd0;
        done       = 1'b0;
        err_out    = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                sub_next = 2'd0;
                if (cmd.req == REQ_PUSH)
                begin
                    if (fill_reg < FILL_W'(MAX_BURST))
                    begin
                        buf_we    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                else if (cmd.req inside {REQ_WRITE, REQ_READ})
                begin
                    raddr_next = cmd.reg_addr;
                    left_next  = cmd.byte_count;
                    rmode_next = (cmd.req == REQ_READ);
                    ptr_next   = '0;
                    err_next   = 1'b0;
                    bit_next   = 4'd0;
                    phase_next = PH_START;
                end
            end
            PH_START, PH_RSTART:
            begin
                case (sub_reg)
                    2'd0: sda_next = 1'b1;
                    2'd1: scl_next = 1'b1;
                    2'd2: sda_next = 1'b0;
                    default:
                    begin
                        scl_next = 1'b0;
                        sub_next = 2'd0;
                        bit_next = 4'd0;
                        if (phase_reg == PH_START)
                        begin
                            phase_next = PH_TX_AW;
                            shift_next = {saddr_reg, 1'b0};
                        end
                        else
                        begin
                            phase_next = PH_TX_AR;
                            shift_next = {saddr_reg, 1'b1};
                        end
                    end
                endcase
            end
            PH_TX_AW, PH_TX_RA, PH_TX_D, PH_TX_AR:
            begin
                case (sub_reg)
                    2'd0:
                    begin
                        sda_next   = shift_reg[7];
                        shift_next = {shift_reg[6:0], 1'b0};
                    end
                    2'd1: scl_next = 1'b1;
                    default:
                    begin
                        scl_next = 1'b0;
                        sub_next = 2'd0;
                        if (bit_reg == BIT_LAST)
                        begin
                            bit_next = 4'd0;
                            case (phase_reg)
                                PH_TX_AW: phase_next = PH_ACK_AW;
                                PH_TX_RA: phase_next = PH_ACK_RA;
                                PH_TX_D:  phase_next = PH_ACK_D;
                                default:  phase_next = PH_ACK_AR;
                            endcase
                        end
                        else
                        begin
                            bit_next = bit_reg + 4'd1;
                        end
                    end
                endcase
            end
            PH_ACK_AW, PH_ACK_RA, PH_ACK_D, PH_ACK_AR:
            begin
                case (sub_reg)
                    2'd0: sda_next = 1'b1;
                    2'd1:
                    begin
                        scl_next = 1'b1;
                        err_next = cmd.sda_in;
                    end
                    default:
                    begin
                        scl_next = 1'b0;
                        sub_next = 2'd0;
                        if (err_reg)
                        begin
                            phase_next = PH_STOP;
                        end
                        else
                        begin
                            case (phase_reg)
                                PH_ACK_AW:
                                begin
                                    phase_next = PH_TX_RA;
                                    shift_next = raddr_reg;
                                    bit_next   = 4'd0;
                                end
                                PH_ACK_RA:
                                begin
                                    if (rmode_reg)
                                    begin
                                        phase_next = PH_RSTART;
                                    end
                                    else
                                    begin
                                        phase_next = PH_TX_D;
                                        shift_next = rd_data_reg;
                                        bit_next   = 4'd0;
                                    end
                                end
                                PH_ACK_D:
                                begin
                                    left_next = left_dec;
                                    ptr_next  = ptr_reg + 1'b1;
                                    if (left_dec == 4'd0)
                                    begin
                                        phase_next = PH_STOP;
                                    end
                                    else
                                    begin
                                        phase_next = PH_TX_D;
                                        shift_next = rd_data_reg;
                                        bit_next   = 4'd0;
                                    end
                                end
                                default:
                                begin
                                    phase_next = PH_RX;
                                    shift_next = 8'd0;
                                    bit_next   = 4'd0;
                                end
                            endcase
                        end
                    end
                endcase
            end
            PH_RX:
            begin
                case (sub_reg)
                    2'd0: sda_next = 1'b1;
                    2'd1:
                    begin
                        scl_next   = 1'b1;
                        shift_next = {shift_reg[6:0], cmd.sda_in};
                    end
                    default:
                    begin
                        scl_next = 1'b0;
                        sub_next = 2'd0;
                        if (bit_reg == BIT_LAST)
                        begin
                            bit_next   = 4'd0;
                            rx_valid   = 1'b1;
                            rx_byte    = shift_reg;
                            phase_next = PH_MACK;
                        end
                        else
                        begin
                            bit_next = bit_reg + 4'd1;
                        end
                    end
                endcase
            end
            PH_MACK:
            begin
                case (sub_reg)
                    // no-acknowledge on the last byte
                    2'd0: sda_next = (left_reg <= 4'd1);
                    2'd1: scl_next = 1'b1;
                    default:
                    begin
                        scl_next  = 1'b0;
                        sub_next  = 2'd0;
                        left_next = left_dec;
                        if (left_dec == 4'd0)
                        begin
                            phase_next = PH_STOP;
                        end
                        else
                        begin
                            phase_next = PH_RX;
                            shift_next = 8'd0;
                            bit_next   = 4'd0;
                        end
                    end
                endcase
            end
            PH_STOP:
            begin
                case (sub_reg)
                    2'd0: sda_next = 1'b0;
                    2'd1: scl_next = 1'b1;
                    default:
                    begin
                        sda_next   = 1'b1;
                        sub_next   = 2'd0;
                        done       = 1'b1;
                        err_out    = err_reg;
                        phase_next = PH_IDLE;
                        if (!rmode_reg)
                        begin
                            fill_next = '0;
                        end
                    end
                endcase
            end
            default:
            begin
                phase_next = PH_IDLE;
                sub_next   = 2'd0;
                scl_next   = 1'b1;
                sda_next   = 1'b1;
            end
        endcase

        res.scl_out     = scl_next;
        res.sda_release = sda_next;
        res.busy_res    = (phase_next != PH_IDLE);
        res.rx_byte     = rx_byte;
        res.rx_valid    = rx_valid;
        res.done_res    = done;
        res.ack_error   = err_out;
    end

    always_ff @(posedge clk)
    begin
        if (step && buf_we)
        begin
            tx_buf[fill_reg[PTR_W-1:0]] <= cmd.data_byte;
        end
        rd_data_reg <= tx_buf[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            sub_reg   <= 2'd0;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            left_reg  <= 4'd0;
            fill_reg  <= '0;
            ptr_reg   <= '0;
            rmode_reg <= 1'b0;
            raddr_reg <= 8'd0;
            err_reg   <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            saddr_reg <= SLAVE_ADDR_RST;
        end
        else
        begin
            if (slave_address_we)
            begin
                saddr_reg <= slave_address;
            end
            if (step)
            begin
                phase_reg <= phase_next;
                sub_reg   <= sub_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                left_reg  <= left_next;
                fill_reg  <= fill_next;
                ptr_reg   <= ptr_next;
                rmode_reg <= rmode_next;
                raddr_reg <= raddr_next;
                err_reg   <= err_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
            end
        end
    end

endmodule

/* rtl/i2crb_resq.sv */
// ----------------------------------------------------------------------------
// i2crb_resq
// Short result queue between the bus engine and the result port.
// ----------------------------------------------------------------------------
module i2crb_resq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_push,
    input  i2crb_pkg::res_t  res_in,
    output logic             res_full,
    output logic             empty,
    input  logic             pop,
    output i2crb_pkg::res_t  res_out
);
    import i2crb_pkg::*;

    res_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign res_full = (count_reg == QCNT_W'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;
    assign res_out  = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/i2c_register_burst_master.sv */
// ----------------------------------------------------------------------------
// i2c_register_burst_master
// I2C master running register write and read bursts, one line phase per tick.
// ----------------------------------------------------------------------------
// Usage:
// Each transaction on the input queue (push / full) is one bus tick carrying a
// request code, the register address, the burst length, a write-data byte and
// the sampled SDA level. Each tick yields exactly one result on the output
// queue (empty / pop): SCL level, SDA release, busy, received byte with its
// valid flag, done and acknowledge error.
// An accepted tick is registered in the request queue and then in the result
// queue before its result is on the ports. One tick per cycle is sustained
// while results are popped; the bus engine retires one tick per cycle
// and stands still only when the result queue is full or no tick is waiting.
// When the consumer stops popping, the two-entry result queue fills, the
// engine holds, then the two-entry request queue fills and full rises.
// Reset empties both queues, returns the engine to idle with SCL and SDA
// released, clears the write buffer fill count and loads the slave address
// with its default. slave_address must be written only while no tick is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module i2c_register_burst_master #(
    parameter int MAX_BURST = i2crb_pkg::MAX_BURST_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       slave_address_we,
    input  logic [6:0] slave_address,
    input  logic       push,
    output logic       full,
    input  logic [1:0] req_type,
    input  logic [7:0] reg_addr,
    input  logic [3:0] byte_count,
    input  logic [7:0] data_byte,
    input  logic       sda_in,
    output logic       empty,
    input  logic       pop,
    output logic       scl_out,
    output logic       sda_release,
    output logic       busy_res,
    output logic [7:0] rx_byte,
    output logic       rx_valid,
    output logic       done_res,
    output logic       ack_error
);
    import i2crb_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic res_full;
    logic step;
    res_t res;
    res_t res_head;

    assign step = cmd_valid && !res_full;

    i2crb_front #(
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .req_type   (req_type),
        .reg_addr   (reg_addr),
        .byte_count (byte_count),
        .data_byte  (data_byte),
        .sda_in     (sda_in),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (step)
    );

    i2crb_engine #(
        .MAX_BURST (MAX_BURST)
    ) u_engine (
        .clk              (clk),
        .rst_n            (rst_n),
        .slave_address_we (slave_address_we),
        .slave_address    (slave_address),
        .step             (step),
        .cmd              (cmd),
        .res              (res)
    );

    i2crb_resq u_resq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (step),
        .res_in   (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .res_out  (res_head)
    );

    assign scl_out     = res_head.scl_out;
    assign sda_release = res_head.sda_release;
    assign busy_res    = res_head.busy_res;
    assign rx_byte     = res_head.rx_byte;
    assign rx_valid    = res_head.rx_valid;
    assign done_res    = res_head.done_res;
    assign ack_error   = res_head.ack_error;

`ifndef SYNTHESIS
    // engine never steps into a full result queue
    a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> !res_full)
        else $error("engine stepped with result queue full");

    // a finished stop always leaves the master idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && done_res) |-> !busy_res)
        else $error("done reported while still busy");

    // an acknowledge error is only reported on the stop tick
    a_err_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && ack_error) |-> done_res)
        else $error("ack error outside done tick");

    // a received byte and a finished stop never share a tick
    a_rx_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rx_valid) |-> (!done_res && busy_res))
        else $error("received byte on a stop tick");
`endif

endmodule

/* bench/i2c_burst_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_burst_checker
// Watches the tick and result queues of the I2C register burst master, works
// out the line levels and flags that every accepted tick must give and compares
// them in order with the results that the consumer pops.
// ----------------------------------------------------------------------------
module i2c_burst_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       slave_address_we,
    input  logic [6:0] slave_address,
    input  logic       push,
    input  logic       full,
    input  logic [1:0] req_type,
    input  logic [7:0] reg_addr,
    input  logic [3:0] byte_count,
    input  logic [7:0] data_byte,
    input  logic       sda_in,
    input  logic       empty,
    input  logic       pop,
    input  logic       scl_out,
    input  logic       sda_release,
    input  logic       busy_res,
    input  logic [7:0] rx_byte,
    input  logic       rx_valid,
    input  logic       done_res,
    input  logic       ack_error,
    output int         fail_count,
    output int         pending_count
);
    import i2crb_pkg::*;

    localparam int BURST_MAX  = MAX_BURST_DEF;
    localparam int BUF_AW     = $clog2(BURST_MAX);
    localparam int REPORT_MAX = 100;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_START,
        PH_TX_AW,
        PH_ACK_AW,
        PH_TX_RA,
        PH_ACK_RA,
        PH_TX_D,
        PH_ACK_D,
        PH_RSTART,
        PH_TX_AR,
        PH_ACK_AR,
        PH_RX,
        PH_MACK,
        PH_STOP
    } phase_t;

    phase_t     phase;
    logic [1:0] sub;
    logic [3:0] bit_no;
    logic [7:0] shifter;
    logic [3:0] left;
    logic [7:0] wbuf [BURST_MAX];
    logic [3:0] fill;
    logic [3:0] rd_ptr;
    logic       rd_mode;
    logic [7:0] reg_latch;
    logic       nacked;
    logic       scl_q;
    logic       sda_q;
    logic [6:0] target;
    res_t       line_results [$];
    int         errors = 0;

    function automatic void load_byte(input phase_t nxt, input logic [7:0] value);
        phase   = nxt;
        shifter = value;
        bit_no  = '0;
    endfunction

    // one line phase of the master: returns what the tick shows on the ports
    function automatic res_t bus_tick(input req_t req, input logic [7:0] ra,
                                      input logic [3:0] cnt, input logic [7:0] db,
                                      input logic sda);
        res_t       r;
        logic [1:0] nsub;
        r    = '0;
        nsub = sub + 2'd1;
        case (phase)
            PH_IDLE:
            begin
                nsub = '0;
                if (req == REQ_PUSH)
                begin
                    if (fill < BURST_MAX)
                    begin
                        wbuf[fill[BUF_AW-1:0]] = db;
                        fill                   = fill + 4'd1;
                    end
                end
                else if (req == REQ_WRITE || req == REQ_READ)
                begin
                    if (cnt == 0)
                        left = 4'd1;
                    else if (cnt > BURST_MAX)
                        left = 4'(BURST_MAX);
                    else
                        left = cnt;
                    reg_latch = ra;
                    rd_mode   = (req == REQ_READ);
                    rd_ptr    = '0;
                    nacked    = 1'b0;
                    bit_no    = '0;
                    phase     = PH_START;
                end
            end
            PH_START, PH_RSTART:
            begin
                if (sub == 2'd0)
                    sda_q = 1'b1;
                else if (sub == 2'd1)
                    scl_q = 1'b1;
                else if (sub == 2'd2)
                    sda_q = 1'b0;
                else
                begin
                    scl_q = 1'b0;
                    nsub  = '0;
                    if (phase == PH_START)
                        load_byte(PH_TX_AW, {target, 1'b0});
                    else
                        load_byte(PH_TX_AR, {target, 1'b1});
                end
            end
            PH_TX_AW, PH_TX_RA, PH_TX_D, PH_TX_AR:
            begin
                if (sub == 2'd0)
                begin
                    sda_q   = shifter[7];
                    shifter = {shifter[6:0], 1'b0};
                end
                else if (sub == 2'd1)
                    scl_q = 1'b1;
                else
                begin
                    scl_q  = 1'b0;
                    nsub   = '0;
                    bit_no = bit_no + 4'd1;
                    if (bit_no >= 4'd8)
                    begin
                        bit_no = '0;
                        // every send phase is followed by its acknowledge phase
                        phase  = phase_t'(phase + 5'd1);
                    end
                end
            end
            PH_ACK_AW, PH_ACK_RA, PH_ACK_D, PH_ACK_AR:
            begin
                if (sub == 2'd0)
                    sda_q = 1'b1;
                else if (sub == 2'd1)
                begin
                    scl_q  = 1'b1;
                    nacked = sda;
                end
                else
                begin
                    scl_q = 1'b0;
                    nsub  = '0;
                    if (nacked)
                        phase = PH_STOP;
                    else if (phase == PH_ACK_AW)
                        load_byte(PH_TX_RA, reg_latch);
                    else if (phase == PH_ACK_RA)
                    begin
                        if (rd_mode)
                            phase = PH_RSTART;
                        else
                            load_byte(PH_TX_D, wbuf[rd_ptr[BUF_AW-1:0]]);
                    end
                    else if (phase == PH_ACK_D)
                    begin
                        if (left > 0)
                            left = left - 4'd1;
                        rd_ptr = rd_ptr + 4'd1;
                        if (left == 0)
                            phase = PH_STOP;
                        else
                            load_byte(PH_TX_D, wbuf[rd_ptr[BUF_AW-1:0]]);
                    end
                    else
                        load_byte(PH_RX, 8'h00);
                end
            end
            PH_RX:
            begin
                if (sub == 2'd0)
                    sda_q = 1'b1;
                else if (sub == 2'd1)
                begin
                    scl_q   = 1'b1;
                    shifter = {shifter[6:0], sda};
                end
                else
                begin
                    scl_q  = 1'b0;
                    nsub   = '0;
                    bit_no = bit_no + 4'd1;
                    if (bit_no >= 4'd8)
                    begin
                        bit_no     = '0;
                        r.rx_valid = 1'b1;
                        r.rx_byte  = shifter;
                        phase      = PH_MACK;
                    end
                end
            end
            PH_MACK:
            begin
                // last byte of the burst gets no acknowledge
                if (sub == 2'd0)
                    sda_q = (left <= 1);
                else if (sub == 2'd1)
                    scl_q = 1'b1;
                else
                begin
                    scl_q = 1'b0;
                    nsub  = '0;
                    if (left > 0)
                        left = left - 4'd1;
                    if (left == 0)
                        phase = PH_STOP;
                    else
                        load_byte(PH_RX, 8'h00);
                end
            end
            PH_STOP:
            begin
                if (sub == 2'd0)
                    sda_q = 1'b0;
                else if (sub == 2'd1)
                    scl_q = 1'b1;
                else
                begin
                    sda_q       = 1'b1;
                    nsub        = '0;
                    r.done_res  = 1'b1;
                    r.ack_error = nacked;
                    if (!rd_mode)
                        fill = '0;
                    phase = PH_IDLE;
                end
            end
            default:
            begin
                phase = PH_IDLE;
                nsub  = '0;
                scl_q = 1'b1;
                sda_q = 1'b1;
            end
        endcase
        sub           = nsub;
        r.scl_out     = scl_q;
        r.sda_release = sda_q;
        r.busy_res    = (phase != PH_IDLE);
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            if (errors <= REPORT_MAX)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            phase     = PH_IDLE;
            sub       = '0;
            bit_no    = '0;
            shifter   = '0;
            left      = '0;
            fill      = '0;
            rd_ptr    = '0;
            rd_mode   = 1'b0;
            reg_latch = '0;
            nacked    = 1'b0;
            scl_q     = 1'b1;
            sda_q     = 1'b1;
            target    = SLAVE_ADDR_RST;
            line_results.delete();
            pending_count <= 0;
            fail_count    <= errors;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (line_results.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("%0t: result with no tick waiting, expected none, actual %0h",
                                 $time, {scl_out, sda_release, busy_res, rx_byte, rx_valid,
                                         done_res, ack_error});
                end
                else
                begin
                    want = line_results.pop_front();
                    check_field("scl_out", want.scl_out, scl_out);
                    check_field("sda_release", want.sda_release, sda_release);
                    check_field("busy_res", want.busy_res, busy_res);
                    check_field("rx_byte", want.rx_byte, rx_byte);
                    check_field("rx_valid", want.rx_valid, rx_valid);
                    check_field("done_res", want.done_res, done_res);
                    check_field("ack_error", want.ack_error, ack_error);
                end
            end
            if (slave_address_we)
                target = slave_address;
            if (push && !full)
                line_results.push_back(bus_tick(req_t'(req_type), reg_addr, byte_count,
                                                data_byte, sda_in));
            pending_count <= line_results.size();
            fail_count    <= errors;
        end
    end

endmodule

/* bench/i2c_register_burst_master_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_register_burst_master_test
// Drives write and read register bursts tick by tick into the I2C master,
// answering acknowledges on the right ticks with the odd one refused, under
// several slave addresses and idling patterns; the checker judges every tick.
// ----------------------------------------------------------------------------
module i2c_register_burst_master_test;
    import i2crb_pkg::*;

    // tick offsets from the start request at which SDA is sampled for an acknowledge
    localparam int ACK_AW_AT   = 30;
    localparam int ACK_RA_AT   = 57;
    localparam int ACK_D0_AT   = 84;
    localparam int ACK_AR_AT   = 88;
    localparam int BYTE_TICKS  = 27;
    localparam int WR_LEN_BASE = 62;
    localparam int RD_LEN_BASE = 93;
    localparam int NACK_TAIL   = 5;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_TICKS = 100;

    logic       clk              = 1'b0;
    logic       rst_n            = 1'b0;
    logic       slave_address_we = 1'b0;
    logic [6:0] slave_address    = '0;
    logic       push             = 1'b0;
    logic [1:0] req_type         = REQ_TICK;
    logic [7:0] reg_addr         = '0;
    logic [3:0] byte_count       = '0;
    logic [7:0] data_byte        = '0;
    logic       sda_in           = 1'b0;
    logic       pop              = 1'b0;
    logic       full;
    logic       empty;
    logic       scl_out;
    logic       sda_release;
    logic       busy_res;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       done_res;
    logic       ack_error;
    int         fail_count;
    int         pending_count;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   ticks_sent     = 0;
    int   hold_left      = 0;
    logic hold_go        = 1'b0;
    logic hold_seen      = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    i2c_register_burst_master u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .slave_address_we (slave_address_we),
        .slave_address    (slave_address),
        .push             (push),
        .full             (full),
        .req_type         (req_type),
        .reg_addr         (reg_addr),
        .byte_count       (byte_count),
        .data_byte        (data_byte),
        .sda_in           (sda_in),
        .empty            (empty),
        .pop              (pop),
        .scl_out          (scl_out),
        .sda_release      (sda_release),
        .busy_res         (busy_res),
        .rx_byte          (rx_byte),
        .rx_valid         (rx_valid),
        .done_res         (done_res),
        .ack_error        (ack_error)
    );

    i2c_burst_checker u_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .slave_address_we (slave_address_we),
        .slave_address    (slave_address),
        .push             (push),
        .full             (full),
        .req_type         (req_type),
        .reg_addr         (reg_addr),
        .byte_count       (byte_count),
        .data_byte        (data_byte),
        .sda_in           (sda_in),
        .empty            (empty),
        .pop              (pop),
        .scl_out          (scl_out),
        .sda_release      (sda_release),
        .busy_res         (busy_res),
        .rx_byte          (rx_byte),
        .rx_valid         (rx_valid),
        .done_res         (done_res),
        .ack_error        (ack_error),
        .fail_count       (fail_count),
        .pending_count    (pending_count)
    );

    // result consumer, with one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            pop       <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_go != hold_seen)
        begin
            hold_seen <= hold_go;
            hold_left <= HOLD_CYCLES;
            pop       <= 1'b0;
        end
        else
            pop <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    task automatic send_tick(input req_t req, input logic [7:0] ra, input logic [3:0] cnt,
                             input logic [7:0] db, input logic sda);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        req_type   <= req;
        reg_addr   <= ra;
        byte_count <= cnt;
        data_byte  <= db;
        sda_in     <= sda;
        @(posedge clk);
        while (full)
            @(posedge clk);
        ticks_sent++;
    endtask

    task automatic idle_ticks(input int count, input int push_pct);
        int i;
        for (i = 0; i < count; i++)
            send_tick(($urandom_range(99, 0) < push_pct) ? REQ_PUSH : REQ_TICK,
                      8'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // a whole burst from the start request to the end of the stop; fail_at picks
    // which acknowledge the slave refuses, line_fill fixes SDA elsewhere (-1 random)
    task automatic run_burst(input bit rd, input logic [7:0] ra, input logic [3:0] cnt,
                             input int fail_at, input int line_fill);
        int   n;
        int   len;
        int   acks;
        int   t;
        bit   sample;
        logic sda;
        n    = (cnt == 0) ? 1 : ((cnt > MAX_BURST_DEF) ? MAX_BURST_DEF : cnt);
        len  = rd ? RD_LEN_BASE + BYTE_TICKS * n : WR_LEN_BASE + BYTE_TICKS * n;
        acks = 0;
        send_tick(rd ? REQ_READ : REQ_WRITE, ra, cnt, 8'($urandom), 1'($urandom));
        for (t = 1; t < len; t++)
        begin
            sample = (t == ACK_AW_AT) || (t == ACK_RA_AT) ||
                     (rd ? (t == ACK_AR_AT) :
                           (t >= ACK_D0_AT && (t - ACK_D0_AT) % BYTE_TICKS == 0));
            sda = (line_fill < 0) ? 1'($urandom_range(1, 0)) : (line_fill != 0);
            if (sample)
            begin
                sda = (acks == fail_at);
                if (sda)
                    len = t + NACK_TAIL;
                acks++;
            end
            // requests while busy are ignored, so they are random here
            send_tick(req_t'($urandom_range(3, 0)), 8'($urandom), 4'($urandom),
                      8'($urandom), sda);
        end
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    task automatic write_target(input logic [6:0] value);
        drain_results();
        repeat (4) @(posedge clk);
        slave_address_we <= 1'b1;
        slave_address    <= value;
        @(posedge clk);
        slave_address_we <= 1'b0;
    endtask

    task automatic random_phase(input bit with_hold);
        int         first;
        logic [3:0] cnt;
        first = ticks_sent;
        if (with_hold)
        begin
            idle_ticks(2, 50);
            hold_go <= ~hold_go;
        end
        while (ticks_sent - first < PHASE_TICKS)
        begin
            idle_ticks($urandom_range(3, 0), 30);
            if ($urandom_range(9, 0) == 0)
                idle_ticks($urandom_range(10, 0), 100);
            cnt = ($urandom_range(3, 0) != 0) ? 4'($urandom_range(2, 1)) :
                                                4'($urandom_range(15, 0));
            run_burst(1'($urandom_range(1, 0)), 8'($urandom), cnt,
                      ($urandom_range(4, 0) == 0) ? $urandom_range(9, 0) : -1, -1);
        end
    endtask

    initial
    begin
        int i;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every buffer entry, then one push into the full buffer
        send_tick(REQ_PUSH, 8'h00, 4'h0, 8'h00, 1'b0);
        send_tick(REQ_PUSH, 8'hFF, 4'hF, 8'hFF, 1'b1);
        for (i = 0; i < 7; i++)
            send_tick(REQ_PUSH, 8'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
        run_burst(1'b0, 8'h00, 4'd0, -1, 0);
        send_tick(REQ_TICK, 8'hFF, 4'hF, 8'hFF, 1'b1);
        // longer than the fill, so stale bytes go out
        run_burst(1'b0, 8'hFF, 4'hF, -1, 1);
        run_burst(1'b1, 8'h5A, 4'd8, -1, 1);
        run_burst(1'b1, 8'hA5, 4'd2, -1, 0);
        run_burst(1'b0, 8'($urandom), 4'd2, 0, -1);
        run_burst(1'b1, 8'($urandom), 4'd3, 1, -1);
        // second data byte refused
        run_burst(1'b0, 8'($urandom), 4'd3, 3, -1);
        run_burst(1'b1, 8'($urandom), 4'd1, 2, -1);

        write_target(7'h00);
        random_phase(1'b1);

        write_target(7'h7F);
        send_idle_pct = 69;
        random_phase(1'b0);

        write_target(7'($urandom));
        send_idle_pct  = 0;
        recv_stall_pct = 69;
        random_phase(1'b0);

        write_target(7'($urandom));
        send_idle_pct  = 31;
        recv_stall_pct = 31;
        random_phase(1'b0);

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
